// ===== hdl/bosc_pkg.sv =====
// ----------------------------------------------------------------------------
// bosc_pkg
// Shared types, constants and helpers for the bit offset stream copier.
// ----------------------------------------------------------------------------
package bosc_pkg;

	localparam int BIT_COUNT_WIDTH_DEF = 16;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_SRC_BIT_OFFSET = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DST_BIT_OFFSET = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_BITS     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DST_HEAD_BYTE  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DST_TAIL_BYTE  = 3'd4;

	// output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	// up to two destination words per source word, packed from w0 up
	typedef struct packed {
		logic [1:0] n;
		word_t      w0;
		word_t      w1;
	} push_t;

	// mask of the n low bits, n in 0..8
	function automatic logic [7:0] low_mask(input logic [3:0] n);
		logic [8:0] m;
		m = (9'd1 << n) - 9'd1;
		return (n >= 4'd8) ? 8'hFF : m[7:0];
	endfunction

endpackage

// ===== hdl/bit_offset_stream_copier_unit.sv =====
// ----------------------------------------------------------------------------
// bit_offset_stream_copier_unit
// Copies a bit run from a source byte stream to a realigned destination
// byte stream, keeping the old bits around the run in the end bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Program src/dst bit offsets, total_bits and the old head/tail bytes
//   through the cfg port while the block is idle. Then stream source bytes
//   in on s_axis; destination bytes come out on m_axis, tlast on the final
//   byte of the run. The next source byte after a run starts a new run.
//   A run of zero bits swallows its input word and emits nothing.
// Path: an accepted word is held in the input register, then merged by the
//   aligner's combinational logic into the output queue that feeds m_axis.
// Throughput: one source word per cycle while the queue has room. The last
//   word of a run may produce two destination words.
// Stall: a stalled receiver fills the four-word output queue; s_axis_tready
//   drops while the input register holds a word and fewer than two queue
//   entries are free.
// Reset: clears config registers, the accumulator and the queue; the block
//   then waits for the first word of a new run.
// ----------------------------------------------------------------------------
module bit_offset_stream_copier_unit #(
	parameter int BIT_COUNT_WIDTH = bosc_pkg::BIT_COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bosc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [BIT_COUNT_WIDTH-1:0]           cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [7:0] src_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // [7:0] dst_byte
	output logic                                 m_axis_tlast   // dst_last
);
	import bosc_pkg::*;

	logic [2:0]                 src_bit_offset_q;
	logic [2:0]                 dst_bit_offset_q;
	logic [BIT_COUNT_WIDTH-1:0] total_bits_q;
	logic [7:0]                 dst_head_byte_q;
	logic [7:0]                 dst_tail_byte_q;
	push_t                      push;
	logic                       room;
	word_t                      out_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_bit_offset_q <= '0;
			dst_bit_offset_q <= '0;
			total_bits_q     <= '0;
			dst_head_byte_q  <= '0;
			dst_tail_byte_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SRC_BIT_OFFSET: src_bit_offset_q <= cfg_data[2:0];
				REG_DST_BIT_OFFSET: dst_bit_offset_q <= cfg_data[2:0];
				REG_TOTAL_BITS:     total_bits_q     <= cfg_data;
				REG_DST_HEAD_BYTE:  dst_head_byte_q  <= cfg_data[7:0];
				REG_DST_TAIL_BYTE:  dst_tail_byte_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	bosc_align #(
		.BIT_COUNT_WIDTH(BIT_COUNT_WIDTH)
	) u_align (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_data       (s_axis_tdata),
		.src_bit_offset(src_bit_offset_q),
		.dst_bit_offset(dst_bit_offset_q),
		.total_bits    (total_bits_q),
		.dst_head_byte (dst_head_byte_q),
		.dst_tail_byte (dst_tail_byte_q),
		.room          (room),
		.push          (push)
	);

	bosc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_word (out_word)
	);

	assign m_axis_tdata = out_word.data;
	assign m_axis_tlast = out_word.last;

`ifndef NO_ASSERTIONS
	// a second word in one cycle is only ever the partial tail of a run
	a_two_words_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.w1.last && !push.w0.last))
		else $error("second word is not the closing tail word");

	// the aligner only pushes when the queue has room for two words
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push into output queue without room");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("more than two words pushed in one cycle");
`endif

endmodule

// ===== hdl/bosc_outq.sv =====
// ----------------------------------------------------------------------------
// bosc_outq
// Small output queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module bosc_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  bosc_pkg::push_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output bosc_pkg::word_t out_word
);
	import bosc_pkg::*;

	word_t                 mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wptr_q;
	logic [OUTQ_PTR_W-1:0] rptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_word  = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	// two free entries needed, since a word may bring two results
	assign room      = (count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[wptr_q + OUTQ_PTR_W'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + OUTQ_PTR_W'(push.n);
			if (pop) begin
				rptr_q <= rptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + OUTQ_CNT_W'(push.n) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/bosc_align.sv =====
// ----------------------------------------------------------------------------
// bosc_align
// Input register plus the bit realigner: merges each source word into the
// bit accumulator and produces finished destination words.
// ----------------------------------------------------------------------------
module bosc_align #(
	parameter int BIT_COUNT_WIDTH = bosc_pkg::BIT_COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 in_data,
	input  logic [2:0]                 src_bit_offset,
	input  logic [2:0]                 dst_bit_offset,
	input  logic [BIT_COUNT_WIDTH-1:0] total_bits,
	input  logic [7:0]                 dst_head_byte,
	input  logic [7:0]                 dst_tail_byte,
	input  logic                       room,
	output bosc_pkg::push_t            push
);
	import bosc_pkg::*;

	localparam int BW = BIT_COUNT_WIDTH;

	logic          valid_s1;
	logic [7:0]    src_s1;

	logic [14:0]   acc_q;
	logic [2:0]    held_q;
	logic [BW-1:0] rem_q;
	logic          first_q;
	logic          one_q;

	logic          fire;
	logic          drop;
	logic [BW-1:0] rem0;
	logic [15:0]   acc0;
	logic [3:0]    held0;
	logic          one_run;
	logic [3:0]    avail;
	logic [7:0]    src_sh;
	logic [3:0]    take;
	logic [7:0]    bits;
	logic [15:0]   acc1;
	logic [3:0]    held1;
	logic [BW-1:0] rem1;
	logic [15:0]   acc2;
	logic [3:0]    held2;
	logic          done;
	logic          full_out;
	logic          tail_out;
	word_t         full_word;
	word_t         tail_word;
	logic [7:0]    keep;
	logic [7:0]    pad;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;
	assign drop     = first_q && (total_bits == '0);

	always_comb begin
		if (first_q) begin
			rem0    = total_bits;
			acc0    = {8'd0, dst_head_byte & low_mask({1'b0, dst_bit_offset})};
			held0   = {1'b0, dst_bit_offset};
			one_run = ({1'b0, total_bits} + (BW+1)'(dst_bit_offset)) <= (BW+1)'(8);
			avail   = 4'd8 - {1'b0, src_bit_offset};
			src_sh  = src_s1 >> src_bit_offset;
		end else begin
			rem0    = rem_q;
			acc0    = {1'b0, acc_q};
			held0   = {1'b0, held_q};
			one_run = one_q;
			avail   = 4'd8;
			src_sh  = src_s1;
		end

		take  = (rem0 < BW'(avail)) ? rem0[3:0] : avail;
		bits  = src_sh & low_mask(take);
		acc1  = acc0 | ({8'd0, bits} << held0);
		held1 = held0 + take;
		rem1  = rem0 - BW'(take);
		done  = (rem1 == '0);

		// at most one whole byte can complete per source word
		full_out       = held1[3];
		full_word.data = acc1[7:0];
		full_word.last = done && (held1 == 4'd8);
		if (full_out) begin
			acc2  = acc1 >> 8;
			held2 = held1 - 4'd8;
		end else begin
			acc2  = acc1;
			held2 = held1;
		end

		// partial last byte, old contents fill the bits above the run
		tail_out       = done && (held2 != 4'd0);
		keep           = low_mask(held2);
		pad            = one_run ? dst_head_byte : dst_tail_byte;
		tail_word.data = (acc2[7:0] & keep) | (pad & ~keep);
		tail_word.last = 1'b1;

		push.w0 = full_out ? full_word : tail_word;
		push.w1 = tail_word;
		if (!fire || drop) begin
			push.n = 2'd0;
		end else begin
			push.n = {1'b0, full_out} + {1'b0, tail_out};
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			src_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			held_q   <= '0;
			rem_q    <= '0;
			first_q  <= 1'b1;
			one_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (fire && !drop) begin
				if (done) begin
					acc_q   <= '0;
					held_q  <= '0;
					rem_q   <= '0;
					first_q <= 1'b1;
					one_q   <= 1'b0;
				end else begin
					acc_q   <= acc2[14:0];
					held_q  <= held2[2:0];
					rem_q   <= rem1;
					first_q <= 1'b0;
					one_q   <= one_run;
				end
			end
		end
	end

endmodule
